FILE: design/packet_frame_receiver_macros.svh
// ---------------------------------------------------------------------------
// packet_frame_receiver_macros.svh
// Assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef PACKET_FRAME_RECEIVER_MACROS_SVH
`define PACKET_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, clocked on clk, held off during reset
`define PFR_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("pfr assertion failed");

// next-cycle implication
`define PFR_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("pfr assertion failed");

`endif

FILE: design/pfr_pkg.sv
// ---------------------------------------------------------------------------
// pfr_pkg
// Types, codes and CRC helpers for the packet frame receiver.
// ---------------------------------------------------------------------------
package pfr_pkg;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_SEQ   = 3'd2,
    PH_HCRC  = 3'd3,
    PH_CMD   = 3'd4,
    PH_BODY  = 3'd5,
    PH_CRC16 = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_ACCEPT   = 2'd1,
    EV_HDR_FAIL = 2'd2,
    EV_CRC_FAIL = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    REG_MAGIC     = 2'd0,
    REG_CHECK_EN  = 2'd1,
    REG_CRC8_POLY = 2'd2,
    REG_CRC16_POLY = 2'd3
  } reg_idx_t;

  localparam logic [7:0]  MAGIC_RST      = 8'h00;
  localparam logic        CHECK_EN_RST   = 1'b0;
  localparam logic [7:0]  CRC8_POLY_RST  = 8'h07;
  localparam logic [15:0] CRC16_POLY_RST = 16'ha001;
  localparam logic [7:0]  CRC8_INIT      = 8'hff;
  localparam logic [15:0] CRC16_INIT     = 16'hffff;

  typedef struct packed {
    logic [7:0]  magic_byte;
    logic        crc_check_enable;
    logic [7:0]  crc8_poly;
    logic [15:0] crc16_poly;
  } cfg_t;

  typedef struct packed {
    logic        body_valid;
    logic [7:0]  body_byte;
    logic [15:0] body_index;
    event_t      frame_event;
    logic [15:0] frame_length;
    logic [7:0]  frame_seq;
    logic [15:0] frame_cmd;
  } result_t;

  // MSB-first CRC-8, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // reflected CRC-16, one byte
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b,
                                               input logic [15:0] poly);
    logic [15:0] c;
    c = {8'h00, crc[7:0] ^ b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = {1'b0, c[15:1]} ^ poly;
      end else begin
        c = {1'b0, c[15:1]};
      end
    end
    return {8'h00, crc[15:8]} ^ c;
  endfunction

endpackage

FILE: design/pfr_cfg_regs.sv
// ---------------------------------------------------------------------------
// pfr_cfg_regs
// APB-style register file: magic byte, check enable and CRC polynomials.
// ---------------------------------------------------------------------------
module pfr_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output pfr_pkg::cfg_t  cfg
);

  pfr_pkg::cfg_t    cfg_r;
  pfr_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = pfr_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_byte       <= pfr_pkg::MAGIC_RST;
      cfg_r.crc_check_enable <= pfr_pkg::CHECK_EN_RST;
      cfg_r.crc8_poly        <= pfr_pkg::CRC8_POLY_RST;
      cfg_r.crc16_poly       <= pfr_pkg::CRC16_POLY_RST;
    end else if (wr_en) begin
      case (idx)
        pfr_pkg::REG_MAGIC:      cfg_r.magic_byte       <= pwdata[7:0];
        pfr_pkg::REG_CHECK_EN:   cfg_r.crc_check_enable <= pwdata[0];
        pfr_pkg::REG_CRC8_POLY:  cfg_r.crc8_poly        <= pwdata[7:0];
        pfr_pkg::REG_CRC16_POLY: cfg_r.crc16_poly       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      pfr_pkg::REG_MAGIC:      prdata = {24'h0, cfg_r.magic_byte};
      pfr_pkg::REG_CHECK_EN:   prdata = {31'h0, cfg_r.crc_check_enable};
      pfr_pkg::REG_CRC8_POLY:  prdata = {24'h0, cfg_r.crc8_poly};
      pfr_pkg::REG_CRC16_POLY: prdata = {16'h0, cfg_r.crc16_poly};
      default:                 prdata = 32'h0;
    endcase
  end

endmodule

FILE: design/pfr_deframer.sv
// ---------------------------------------------------------------------------
// pfr_deframer
// Frame parser state and byte-wide CRC-8 / CRC-16 update for one byte.
// ---------------------------------------------------------------------------
module pfr_deframer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  pfr_pkg::cfg_t    cfg,
  output pfr_pkg::result_t res
);

  pfr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic [7:0]  crc8_r, crc8_nxt;
  logic [15:0] crc16_r, crc16_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;

  logic [7:0]  crc8_upd, crc8_first;
  logic [15:0] crc16_upd, crc16_first;
  logic [15:0] cnt_inc;
  logic [15:0] rcrc_full;

  assign crc8_upd    = pfr_pkg::crc8_update(crc8_r, rx_byte, cfg.crc8_poly);
  assign crc8_first  = pfr_pkg::crc8_update(pfr_pkg::CRC8_INIT, rx_byte, cfg.crc8_poly);
  assign crc16_upd   = pfr_pkg::crc16_update(crc16_r, rx_byte, cfg.crc16_poly);
  assign crc16_first = pfr_pkg::crc16_update(pfr_pkg::CRC16_INIT, rx_byte, cfg.crc16_poly);
  assign cnt_inc     = cnt_r + 16'd1;
  assign rcrc_full   = {rx_byte, rcrc_r[7:0]};

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    seq_nxt   = seq_r;
    cmd_nxt   = cmd_r;
    crc8_nxt  = crc8_r;
    crc16_nxt = crc16_r;
    rcrc_nxt  = rcrc_r;
    case (phase_r)
      pfr_pkg::PH_LEN: begin
        crc8_nxt  = crc8_upd;
        crc16_nxt = crc16_upd;
        if (cnt_r == 16'd0) begin
          len_nxt = {len_r[15:8], rx_byte};
          cnt_nxt = 16'd1;
        end else begin
          len_nxt   = {rx_byte, len_r[7:0]};
          cnt_nxt   = 16'd0;
          phase_nxt = pfr_pkg::PH_SEQ;
        end
      end
      pfr_pkg::PH_SEQ: begin
        crc8_nxt  = crc8_upd;
        crc16_nxt = crc16_upd;
        seq_nxt   = rx_byte;
        phase_nxt = pfr_pkg::PH_HCRC;
      end
      pfr_pkg::PH_HCRC: begin
        crc16_nxt = crc16_upd;
        cnt_nxt   = 16'd0;
        if (cfg.crc_check_enable && (crc8_r != rx_byte)) begin
          phase_nxt = pfr_pkg::PH_HUNT;
        end else begin
          phase_nxt = pfr_pkg::PH_CMD;
        end
      end
      pfr_pkg::PH_CMD: begin
        crc16_nxt = crc16_upd;
        if (cnt_r == 16'd0) begin
          cmd_nxt = {cmd_r[15:8], rx_byte};
          cnt_nxt = 16'd1;
        end else begin
          cmd_nxt   = {rx_byte, cmd_r[7:0]};
          cnt_nxt   = 16'd0;
          phase_nxt = (len_r == 16'd0) ? pfr_pkg::PH_CRC16 : pfr_pkg::PH_BODY;
        end
      end
      pfr_pkg::PH_BODY: begin
        crc16_nxt = crc16_upd;
        if (cnt_inc == len_r) begin
          cnt_nxt   = 16'd0;
          phase_nxt = pfr_pkg::PH_CRC16;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      pfr_pkg::PH_CRC16: begin
        if (cnt_r == 16'd0) begin
          rcrc_nxt = {rcrc_r[15:8], rx_byte};
          cnt_nxt  = 16'd1;
        end else begin
          rcrc_nxt  = rcrc_full;
          cnt_nxt   = 16'd0;
          phase_nxt = pfr_pkg::PH_HUNT;
        end
      end
      default: begin
        // hunting, and any unused code
        phase_nxt = pfr_pkg::PH_HUNT;
        if (rx_byte == cfg.magic_byte) begin
          crc8_nxt  = crc8_first;
          crc16_nxt = crc16_first;
          len_nxt   = 16'd0;
          cmd_nxt   = 16'd0;
          rcrc_nxt  = 16'd0;
          cnt_nxt   = 16'd0;
          phase_nxt = pfr_pkg::PH_LEN;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    res.body_valid   = 1'b0;
    res.body_byte    = 8'h00;
    res.body_index   = 16'h0000;
    res.frame_event  = pfr_pkg::EV_NONE;
    res.frame_length = len_nxt;
    res.frame_seq    = seq_nxt;
    res.frame_cmd    = cmd_nxt;
    case (phase_r)
      pfr_pkg::PH_HCRC: begin
        if (cfg.crc_check_enable && (crc8_r != rx_byte)) begin
          res.frame_event = pfr_pkg::EV_HDR_FAIL;
        end
      end
      pfr_pkg::PH_BODY: begin
        res.body_valid = 1'b1;
        res.body_byte  = rx_byte;
        res.body_index = cnt_r;
      end
      pfr_pkg::PH_CRC16: begin
        if (cnt_r != 16'd0) begin
          if (cfg.crc_check_enable && (crc16_r != rcrc_full)) begin
            res.frame_event = pfr_pkg::EV_CRC_FAIL;
          end else begin
            res.frame_event = pfr_pkg::EV_ACCEPT;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pfr_pkg::PH_HUNT;
      cnt_r   <= 16'd0;
      len_r   <= 16'd0;
      seq_r   <= 8'd0;
      cmd_r   <= 16'd0;
      crc8_r  <= pfr_pkg::CRC8_INIT;
      crc16_r <= pfr_pkg::CRC16_INIT;
      rcrc_r  <= 16'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      seq_r   <= seq_nxt;
      cmd_r   <= cmd_nxt;
      crc8_r  <= crc8_nxt;
      crc16_r <= crc16_nxt;
      rcrc_r  <= rcrc_nxt;
    end
  end

endmodule

FILE: design/packet_frame_receiver.sv
// ---------------------------------------------------------------------------
// packet_frame_receiver
// Byte-stream deframer with header CRC-8 and frame CRC-16 checking.
// ---------------------------------------------------------------------------
// Takes one byte per beat and returns one result per byte. Frames are a magic
// byte, 16-bit LE length, sequence byte, header CRC-8, 16-bit LE command id,
// the body and a 16-bit LE CRC-16. Throughput is one byte every clock while the
// output does not stall; an accepted byte sits in the input register while the
// parser's combinational CRC update feeds the result register, which drives
// out_tdata. Stalls on the output back up through both registers; no beat is
// dropped.
module packet_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] body_byte, [23:8] body_index,
                                  // [25:24] frame_event, [41:26] frame_length,
                                  // [49:42] frame_seq, [65:50] frame_cmd, rest 0
  output logic        out_tuser,  // [0] body_valid
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pfr_pkg::cfg_t    cfg;
  pfr_pkg::result_t res;
  pfr_pkg::result_t out_r;
  logic             in_vld_r, out_vld_r;
  logic [7:0]       in_byte_r;
  logic             adv;

  pfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pfr_deframer u_dfr (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_r.body_valid;
  assign out_tdata  = {6'h00, out_r.frame_cmd, out_r.frame_seq, out_r.frame_length,
                       out_r.frame_event, out_r.body_index, out_r.body_byte};

endmodule

FILE: design/pfr_checker.sv
// ---------------------------------------------------------------------------
// pfr_checker
// Port-level checks on the packet frame receiver result stream.
// ---------------------------------------------------------------------------
`include "packet_frame_receiver_macros.svh"

module pfr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tuser
);

  logic body_beat, idle_beat, in_beat;

  assign body_beat = out_tvalid && out_tuser;
  assign idle_beat = out_tvalid && !out_tuser;
  assign in_beat   = in_tvalid && in_tready;

  // stalled result holds
  `PFR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // a body byte never carries a frame event
  `PFR_ASSERT_IMPL(a_body_no_event, body_beat, out_tdata[25:24] == 2'd0)

  // body index stays inside the frame length
  `PFR_ASSERT_IMPL(a_body_index, body_beat, out_tdata[23:8] < out_tdata[41:26])

  // non-body results carry zero byte and index
  `PFR_ASSERT_IMPL(a_idle_zero, idle_beat, out_tdata[23:0] == 24'h0)

  // an accepted beat shows as a valid result once past the input and result registers
  `PFR_ASSERT_IMPL(a_in_flow, $past(in_beat, 2) && $past(rst_n), out_tvalid)

endmodule

bind packet_frame_receiver pfr_checker u_pfr_checker (.*);
